@@ design/etd_pkg.sv @@
// ----------------------------------------------------------------------------
// etd_pkg
// Shared types, character codes and helper functions for the escaped text
// decoder.
// ----------------------------------------------------------------------------
package etd_pkg;

  typedef enum logic [2:0] {
    MODE_PLAIN  = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_DEC    = 3'd2,
    MODE_XFIRST = 3'd3,
    MODE_XSEC   = 3'd4,
    MODE_XDEAD  = 3'd5
  } mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] chr;
    logic       has_byte;
    logic       eos;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } step_out_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] d;
    h.ok  = 1'b0;
    h.val = 4'd0;
    d     = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - CH_ZERO;
      h.ok = 1'b1;
      h.val = d[3:0];
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - CH_LOWER_A + 8'd10;
      h.ok = 1'b1;
      h.val = d[3:0];
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - CH_UPPER_A + 8'd10;
      h.ok = 1'b1;
      h.val = d[3:0];
    end
    return h;
  endfunction

  function automatic logic [7:0] control_code(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h72: r = 8'd13;
      8'h6E: r = 8'd10;
      8'h74: r = 8'd9;
      8'h62: r = 8'd8;
      8'h61: r = 8'd7;
      8'h66: r = 8'd12;
      8'h76: r = 8'd11;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

@@ design/etd_step.sv @@
// ----------------------------------------------------------------------------
// etd_step
// Escape state machine: decodes one registered byte per fire and yields up to
// two result words.
// ----------------------------------------------------------------------------
module etd_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          chr,
  input  logic                last,
  output etd_pkg::step_out_t  res
);
  import etd_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] esc_val, esc_val_next;
  logic [1:0] digit_count, digit_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PLAIN;
      esc_val     <= 8'd0;
      digit_count <= 2'd0;
    end else if (fire) begin
      mode        <= mode_next;
      esc_val     <= esc_val_next;
      digit_count <= digit_count_next;
    end
  end

  always_comb begin
    hex_t       h;
    logic       is_dig;
    logic       as_plain;
    logic [1:0] n;
    logic [7:0] v0, v1, emit_val, dval;
    logic [1:0] cnt_inc;

    h                = hex_decode(chr);
    is_dig           = chr inside {[8'h30:8'h39]};
    dval             = chr - CH_ZERO;
    as_plain         = 1'b0;
    n                = 2'd0;
    v0               = 8'd0;
    v1               = 8'd0;
    emit_val         = 8'd0;
    cnt_inc          = digit_count + 2'd1;
    mode_next        = mode;
    esc_val_next     = esc_val;
    digit_count_next = digit_count;

    case (mode)
      MODE_ESC: begin
        if (is_dig) begin
          esc_val_next     = dval;
          digit_count_next = 2'd1;
          mode_next        = MODE_DEC;
        end else if (chr == CH_X) begin
          mode_next = MODE_XFIRST;
        end else begin
          v0        = control_code(chr);
          n         = 2'd1;
          mode_next = MODE_PLAIN;
        end
      end
      MODE_DEC: begin
        if (is_dig && digit_count != 2'd3) begin
          esc_val_next     = 8'((esc_val * 8'd10) + dval);
          digit_count_next = cnt_inc;
          if (cnt_inc == 2'd3) begin
            v0        = esc_val_next;
            n         = 2'd1;
            mode_next = MODE_PLAIN;
          end
        end else begin
          v0        = esc_val;
          n         = 2'd1;
          mode_next = MODE_PLAIN;
          as_plain  = 1'b1;
        end
      end
      MODE_XFIRST: begin
        if (h.ok) begin
          esc_val_next = {4'd0, h.val};
          mode_next    = MODE_XSEC;
        end else begin
          esc_val_next = 8'd0;
          mode_next    = MODE_XDEAD;
        end
      end
      MODE_XSEC, MODE_XDEAD: begin
        emit_val = (mode == MODE_XSEC) ? esc_val : 8'd0;
        if (h.ok) begin
          if (mode == MODE_XSEC) begin
            emit_val = {esc_val[3:0], h.val};
          end
        end else begin
          as_plain = 1'b1;
        end
        v0        = emit_val;
        n         = 2'd1;
        mode_next = MODE_PLAIN;
      end
      default: begin
        as_plain = 1'b1;
      end
    endcase

    if (as_plain) begin
      if (chr == CH_BACKSLASH) begin
        mode_next = MODE_ESC;
      end else begin
        mode_next = MODE_PLAIN;
        if (n == 2'd0) begin
          v0 = chr;
        end else begin
          v1 = chr;
        end
        n = n + 2'd1;
      end
    end

    res.r0.chr      = v0;
    res.r0.has_byte = 1'b1;
    res.r0.eos      = 1'b0;
    res.r1.chr      = v1;
    res.r1.has_byte = 1'b1;
    res.r1.eos      = 1'b0;

    if (last) begin
      // flush a pending numeric escape
      if (mode_next == MODE_DEC || mode_next == MODE_XSEC || mode_next == MODE_XDEAD) begin
        emit_val = (mode_next == MODE_XDEAD) ? 8'd0 : esc_val_next;
        if (n == 2'd0) begin
          res.r0.chr = emit_val;
        end else begin
          res.r1.chr = emit_val;
        end
        n = n + 2'd1;
      end
      if (n == 2'd0) begin
        res.r0.chr      = 8'd0;
        res.r0.has_byte = 1'b0;
        n               = 2'd1;
      end
      if (n == 2'd1) begin
        res.r0.eos = 1'b1;
      end else begin
        res.r1.eos = 1'b1;
      end
      mode_next        = MODE_PLAIN;
      esc_val_next     = 8'd0;
      digit_count_next = 2'd0;
    end

    res.n = n;
  end

endmodule

@@ design/etd_outq.sv @@
// ----------------------------------------------------------------------------
// etd_outq
// Small result queue: takes up to two words per cycle, hands out one word per
// cycle on a valid/ready channel.
// ----------------------------------------------------------------------------
module etd_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  etd_pkg::step_out_t  wr,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output etd_pkg::res_t       rd
);
  import etd_pkg::*;

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count, count_next;
  logic           pop;
  logic [QAW:0]   push_n;
  logic [QAW-1:0] wr_ptr_p1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign room      = (count <= (QAW+1)'(QDEPTH - 2));
  assign push_n    = push ? (QAW+1)'(wr.n) : '0;
  assign wr_ptr_p1 = wr_ptr + 1'b1;
  assign rd        = mem[rd_ptr];

  always_comb begin
    count_next = count + push_n - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push && wr.n != 2'd0) begin
      mem[wr_ptr] <= wr.r0;
    end
    if (push && wr.n == 2'd2) begin
      mem[wr_ptr_p1] <= wr.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[QAW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

@@ design/escaped_text_decoder.sv @@
// ----------------------------------------------------------------------------
// escaped_text_decoder
// Decodes backslash escapes in a quoted text body, one byte per word.
// ----------------------------------------------------------------------------
// each byte goes through the input register, then the result queue
// throughput: one input word per cycle while results drain one per cycle;
//   a byte that ends a numeric escape as a plain byte gives two words in a
//   four-entry result queue that holds input back while three or more wait
// reset: synchronous; returns to plain text mode and empties the queue
module escaped_text_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       end_of_string
);
  import etd_pkg::*;

  logic      pend;
  logic [7:0] chr_r;
  logic      last_r;
  logic      room;
  logic      fire;
  step_out_t step_res;
  res_t      rd;

  assign fire     = pend && room;
  assign in_ready = !pend || room;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (in_ready) begin
      pend <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      chr_r  <= in_byte;
      last_r <= in_last;
    end
  end

  etd_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .chr  (chr_r),
    .last (last_r),
    .res  (step_res)
  );

  etd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .wr        (step_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rd        (rd)
  );

  assign out_byte      = rd.chr;
  assign has_byte      = rd.has_byte;
  assign end_of_string = rd.eos;

endmodule
